// File: design/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Types and constants of the entity decoder: entity texts, lengths, values
// and the result buffer entry.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int ENT_COUNT  = 5;
  localparam int ENT_MAXLEN = 6;
  localparam int HOLD_DEPTH = 5;
  localparam int RES_DEPTH  = 6;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;

  localparam logic [10:0] MAX_LENGTH_RST = 11'd768;

  // entity text, first character in the top byte, unused tail zero
  localparam logic [8*ENT_MAXLEN-1:0] ENT_TEXT [ENT_COUNT] = '{
    "&quot;",
    {"&amp;", 8'h00},
    "&apos;",
    {"&lt;", 16'h0000},
    {"&gt;", 16'h0000}
  };

  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd6, 3'd5, 3'd6, 3'd4, 3'd4};

  localparam logic [7:0] ENT_VAL [ENT_COUNT] = '{8'h22, 8'h26, 8'h27, 8'h3C, 8'h3E};

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } res_t;

endpackage

// File: design/html_entity_decoder.sv
// A byte is registered, then loaded into the result buffer driving the output.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_stall is low; a byte that yields several results (failed entity match,
// terminator flush, up to 6) sends them in turn, and the input stalls until
// the last is taken. Reset (rst_n low, synchronous) empties both stages,
// clears the held bytes and the emitted count, and sets max_length to 768.
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming decoder for &quot; &amp; &apos; &lt; &gt;, with LF/CR to space
// and an output length cap; one terminator result closes each string.
// ----------------------------------------------------------------------------
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_out,
  output logic        out_is_terminator
);

  logic [10:0] max_length_r;
  logic        inr_valid_r;
  logic [7:0]  inr_char_r;
  logic        inr_eos_r;
  logic [7:0]  held_r [HOLD_DEPTH];
  logic [2:0]  held_cnt_r;
  logic [2:0]  held_cnt_nxt;
  logic [10:0] emitted_r;
  logic [10:0] emitted_nxt;
  res_t        rbuf_r [RES_DEPTH];
  res_t        rbuf_nxt [RES_DEPTH];
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_nxt;

  logic        out_xfer;
  logic        buf_free;
  logic        move;

  logic [7:0]  cand [RES_DEPTH];
  logic [7:0]  list [RES_DEPTH];
  logic [2:0]  n;
  logic        eq;
  logic        full;
  logic        pfx;
  logic [7:0]  fval;
  logic [7:0]  mapped;
  logic        is_amp;
  logic [2:0]  len;
  logic        trail;
  logic [11:0] diff;
  logic [2:0]  room;
  logic [2:0]  k;
  logic        hold_pfx;

  assign out_valid         = (cnt_r != 3'd0);
  assign out_char_out      = rbuf_r[0].ch;
  assign out_is_terminator = rbuf_r[0].term;
  assign out_xfer          = out_valid && !out_stall;
  assign buf_free          = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_xfer);
  assign move              = inr_valid_r && buf_free;
  assign in_stall          = inr_valid_r && !buf_free;

  // decode of the registered byte against the held prefix
  always_comb begin
    eq     = 1'b0;
    full   = 1'b0;
    pfx    = 1'b0;
    fval   = 8'h00;
    mapped = ((inr_char_r == CH_LF) || (inr_char_r == CH_CR)) ? CH_SPACE : inr_char_r;
    is_amp = (inr_char_r == CH_AMP);
    n      = held_cnt_r + 3'd1;

    for (int j = 0; j < HOLD_DEPTH; j++) begin
      cand[j] = (3'(j) < held_cnt_r) ? held_r[j] : inr_char_r;
      list[j] = (3'(j) < held_cnt_r) ? held_r[j] : mapped;
    end
    cand[RES_DEPTH-1] = inr_char_r;
    list[RES_DEPTH-1] = mapped;

    for (int e = 0; e < ENT_COUNT; e++) begin
      eq = 1'b1;
      for (int j = 0; j < ENT_MAXLEN; j++) begin
        if ((3'(j) < n) && (cand[j] != ENT_TEXT[e][(ENT_MAXLEN-1-j)*8 +: 8])) begin
          eq = 1'b0;
        end
      end
      if (eq && (n == ENT_LEN[e])) begin
        full = 1'b1;
        fval = ENT_VAL[e];
      end
      if (eq && (n < ENT_LEN[e])) begin
        pfx = 1'b1;
      end
    end

    // free slots left under the cap, saturated
    diff = {1'b0, max_length_r} - {1'b0, emitted_r} - 12'd1;
    if (diff[11]) begin
      room = 3'd0;
    end else if (|diff[10:3]) begin
      room = 3'd7;
    end else begin
      room = diff[2:0];
    end

    trail    = 1'b0;
    hold_pfx = 1'b0;
    if (inr_eos_r) begin
      len = held_cnt_r;
    end else if (held_cnt_r == 3'd0) begin
      len   = {2'b00, !is_amp};
      trail = is_amp;
    end else if (full) begin
      list[0] = fval;
      len     = 3'd1;
    end else if (pfx) begin
      len      = 3'd0;
      hold_pfx = 1'b1;
    end else begin
      // broken match: held bytes go out literally, new byte treated afresh
      len   = held_cnt_r + {2'b00, !is_amp};
      trail = is_amp;
    end

    k = (len < room) ? len : room;

    if (inr_eos_r) begin
      held_cnt_nxt = 3'd0;
      emitted_nxt  = 11'd0;
    end else begin
      emitted_nxt = emitted_r + 11'(k);
      if (hold_pfx) begin
        held_cnt_nxt = n;
      end else if (trail && (room > k)) begin
        held_cnt_nxt = 3'd1;
      end else begin
        held_cnt_nxt = 3'd0;
      end
    end
  end

  // result buffer: load a whole item, drain from entry 0
  always_comb begin
    if (move) begin
      for (int j = 0; j < RES_DEPTH; j++) begin
        rbuf_nxt[j].ch   = (3'(j) < k) ? list[j] : 8'h00;
        rbuf_nxt[j].term = inr_eos_r && (3'(j) == k);
      end
      cnt_nxt = k + {2'b00, inr_eos_r};
    end else if (out_xfer) begin
      for (int j = 0; j < RES_DEPTH - 1; j++) begin
        rbuf_nxt[j] = rbuf_r[j+1];
      end
      rbuf_nxt[RES_DEPTH-1] = rbuf_r[RES_DEPTH-1];
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      for (int j = 0; j < RES_DEPTH; j++) begin
        rbuf_nxt[j] = rbuf_r[j];
      end
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
      inr_valid_r  <= 1'b0;
      held_cnt_r   <= 3'd0;
      emitted_r    <= 11'd0;
      cnt_r        <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        max_length_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        inr_valid_r <= in_valid;
      end
      if (move) begin
        held_cnt_r <= held_cnt_nxt;
        emitted_r  <= emitted_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inr_char_r <= in_char_in;
      inr_eos_r  <= in_end_of_string;
    end
    if (move) begin
      for (int j = 0; j < HOLD_DEPTH; j++) begin
        if (hold_pfx && (3'(j) == held_cnt_r)) begin
          held_r[j] <= inr_char_r;
        end else if (!inr_eos_r && trail && (j == 0)) begin
          held_r[j] <= CH_AMP;
        end
      end
    end
    for (int j = 0; j < RES_DEPTH; j++) begin
      rbuf_r[j] <= rbuf_nxt[j];
    end
  end

endmodule

// File: verif/html_entity_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_decoder_tb
// Streams random and hand-picked strings through the entity decoder under
// bursty input and a stalling output, predicts every decoded byte and
// terminator in step with the input transfers, and checks them in order.
// The length cap is moved through its extremes between strings.
// ----------------------------------------------------------------------------
module html_entity_decoder_tb;
  import hed_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } raw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = '0;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char_out;
  logic        out_is_terminator;

  html_entity_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_end_of_string  (in_end_of_string),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_out      (out_char_out),
    .out_is_terminator (out_is_terminator)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  raw_t raw_q[$];
  res_t decoded_q[$];
  res_t want;

  int queued_n = 0;
  int in_count = 0;
  int out_count = 0;
  int term_count = 0;
  int fail_cnt = 0;
  int quiet = 0;
  int settings_n = 1;
  logic in_fired = 1'b0;

  // decoder state as the testbench sees it
  logic [10:0] cap_len = MAX_LENGTH_RST;
  logic [7:0]  held [HOLD_DEPTH];
  int          held_n = 0;
  int          emit_n = 0;

  function automatic string ent_text(input int k);
    case (k)
      0: return "&quot;";
      1: return "&amp;";
      2: return "&apos;";
      3: return "&lt;";
      default: return "&gt;";
    endcase
  endfunction

  function automatic logic [7:0] ent_value(input int k);
    case (k)
      0: return 8'h22;
      1: return CH_AMP;
      2: return 8'h27;
      3: return 8'h3C;
      default: return 8'h3E;
    endcase
  endfunction

  function automatic bit has_space();
    return emit_n + 1 < int'(cap_len);
  endfunction

  task automatic put_char(input logic [7:0] c);
    if (has_space()) begin
      decoded_q.push_back('{ch: c, term: 1'b0});
      emit_n++;
    end
  endtask

  task automatic plain_byte(input logic [7:0] b);
    if (b == CH_AMP) begin
      // an ampersand past the cap is dropped, not held
      if (has_space()) begin
        held[0] = b;
        held_n = 1;
      end
    end else if (b == CH_LF || b == CH_CR) begin
      put_char(CH_SPACE);
    end else begin
      put_char(b);
    end
  endtask

  task automatic held_byte(input logic [7:0] b);
    logic [7:0] cand [HOLD_DEPTH+1];
    int n;
    bit part;
    bit same;
    string s;
    n = held_n;
    for (int i = 0; i < n; i++) cand[i] = held[i];
    cand[n] = b;
    n++;
    part = 0;
    for (int k = 0; k < ENT_COUNT; k++) begin
      s = ent_text(k);
      if (n <= s.len()) begin
        same = 1;
        for (int i = 0; i < n; i++)
          if (cand[i] != s[i]) same = 0;
        if (same) begin
          if (n == s.len()) begin
            held_n = 0;
            put_char(ent_value(k));
            return;
          end
          part = 1;
        end
      end
    end
    if (part && n <= HOLD_DEPTH) begin
      held[n-1] = b;
      held_n = n;
      return;
    end
    // broken match: ampersand goes out as is, the rest is looked at again
    held_n = 0;
    put_char(cand[0]);
    for (int i = 1; i < n; i++) plain_byte(cand[i]);
  endtask

  task automatic decode_item(input logic [7:0] ch, input logic eos);
    if (eos) begin
      for (int i = 0; i < held_n; i++) put_char(held[i]);
      held_n = 0;
      decoded_q.push_back('{ch: 8'h00, term: 1'b1});
      emit_n = 0;
    end else if (held_n == 0) begin
      plain_byte(ch);
    end else begin
      held_byte(ch);
    end
  endtask

  // checker and predictor, both on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cap_len = MAX_LENGTH_RST;
      held_n = 0;
      emit_n = 0;
      for (int i = 0; i < HOLD_DEPTH; i++) held[i] = '0;
      in_fired <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_count++;
        if (out_is_terminator) term_count++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: char_out 0x%02h is_terminator %0b",
                 out_char_out, out_is_terminator);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_char_out !== want.ch) begin
            $error("char_out: expected 0x%02h, got 0x%02h", want.ch, out_char_out);
            fail_cnt++;
          end
          if (out_is_terminator !== want.term) begin
            $error("is_terminator: expected %0b, got %0b", want.term,
                   out_is_terminator);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_item(in_char_in, in_end_of_string);
        in_count++;
      end
      if (cfg_wr_en) cap_len = cfg_wr_data;
      in_fired <= in_valid && !in_stall;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 8;
  int gap_left = 0;
  raw_t nxt;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // stalled: hold the payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (raw_q.size() > 0) begin
      nxt = raw_q.pop_front();
      in_char_in <= nxt.ch;
      in_end_of_string <= nxt.eos;
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern of its own plus a long hold-off now and then
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  int next_hold = 150;

  always @(negedge clk) begin
    rx_cycle++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (in_count >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += 150;
      out_stall <= 1'b1;
    end else begin
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= rx_cycle[0];
      endcase
    end
  end

  task automatic push_raw(input logic [7:0] ch, input logic eos);
    raw_q.push_back('{ch: ch, eos: eos});
    queued_n++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_raw(s[i], 1'b0);
  endtask

  task automatic push_prefix(input int k);
    string s;
    int p;
    s = ent_text(k);
    p = $urandom_range(1, s.len() - 1);
    for (int i = 0; i < p; i++) push_raw(s[i], 1'b0);
  endtask

  // one string: mostly entities and near misses with random filler
  task automatic add_string(input int ntok);
    int r;
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_text(ent_text($urandom_range(0, ENT_COUNT - 1)));
      end else if (r < 55) begin
        push_prefix($urandom_range(0, ENT_COUNT - 1));
        push_raw(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 62) begin
        push_raw(CH_AMP, 1'b0);
      end else if (r < 72) begin
        push_raw($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
      end else if (r < 77) begin
        case ($urandom_range(0, 2))
          0: push_raw(8'h00, 1'b0);
          1: push_raw(8'hFF, 1'b0);
          default: push_raw(8'h80, 1'b0);
        endcase
      end else begin
        push_raw(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    // sometimes end the string in the middle of an entity
    if ($urandom_range(0, 99) < 15) push_prefix($urandom_range(0, ENT_COUNT - 1));
    push_raw(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic random_phase();
    int target;
    target = queued_n + PHASE_ITEMS;
    while (queued_n < target) add_string($urandom_range(0, 8));
  endtask

  task automatic wait_drained();
    while (in_count != queued_n || decoded_q.size() != 0) @(negedge clk);
    // a held ampersand may still sit in the pipe with nothing owed
    repeat (10) @(negedge clk);
  endtask

  task automatic set_cap(input logic [10:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_n++;
  endtask

  logic [10:0] cap_plan [9] = '{11'd1024, 11'd1, 11'd0, 11'd2, 11'd5,
                                11'd2047, 11'd3, 11'd9, 11'd768};

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every entity back to back, then the odd bytes and a flush
    push_text("&quot;&amp;&apos;&lt;&gt;");
    push_raw(8'h00, 1'b1);
    push_raw(CH_LF, 1'b0);
    push_raw(CH_CR, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'hFF, 1'b0);
    push_text("&ap");
    push_raw(8'hFF, 1'b1);
    push_raw(8'h00, 1'b1);
    random_phase();

    foreach (cap_plan[i]) begin
      wait_drained();
      set_cap(cap_plan[i]);
      random_phase();
    end
    wait_drained();

    $display("%0d bytes in, %0d results out over %0d strings", in_count, out_count,
             term_count);
    $display("%0d length cap settings, 0 and 2047 among them", settings_n);
    if (fail_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/hed_pkg.sv
design/html_entity_decoder.sv
verif/html_entity_decoder_tb.sv
